[src/esmc_pkg.sv]
`timescale 1ns / 1ps

package esmc_pkg;

	localparam int FLOORS_DEF = 4;

	// iterative divider size: magnitude of a 17b x 18b product, 18b divisor
	localparam int DIV_NW = 34;
	localparam int DIV_DW = 18;

	localparam logic [15:0] MIN_PERIOD_RST   = 16'd200;
	localparam logic [15:0] MAX_PERIOD_RST   = 16'd2000;
	localparam logic [17:0] ACCEL_RST        = 18'd3200;
	localparam logic [17:0] DECEL_RST        = 18'd3200;
	localparam logic [17:0] SPF_RST          = 18'd61600;
	localparam logic [23:0] DWELL_RST        = 24'd3000000;
	localparam logic [7:0]  BACKOFF_RST      = 8'd100;
	localparam logic [15:0] BACKOFF_PER_RST  = 16'd1000;
	localparam logic [15:0] HOMING_PER_RST   = 16'd2000;

	typedef enum logic [1:0] {
		MODE_BUTTON,
		MODE_REQUEST,
		MODE_TICK,
		MODE_NOP
	} mode_t;

	typedef enum logic [2:0] {
		REG_MIN_PERIOD,
		REG_MAX_PERIOD,
		REG_ACCEL,
		REG_DECEL,
		REG_SPF,
		REG_DWELL,
		REG_BACKOFF,
		REG_BACKOFF_PER
	} cfg_reg_t;

	// countdown load: a period of P waits P ticks, zero acts as one
	function automatic logic [15:0] load_period(logic [15:0] p);
		return (p == 16'd0) ? 16'd0 : p - 16'd1;
	endfunction

endpackage

[src/elevator_stepper_motion_controller.sv]
`timescale 1ns / 1ps

// Elevator scheduler and stepper controller.
// Input channel (in_valid/in_stall): mode, floor, bottom_limit, driver_fault.
// Mode 0 is a button, 1 an external request, 2 a one-microsecond tick that
// samples the limit switch and driver fault, 3 does nothing but still answers.
// Every input beat gives exactly one result beat (out_valid/out_stall) with
// step_pulse, direction, floor and target, heading and status flags.
// Sequence: a taken beat is evaluated in EXEC and its result is loaded in DONE;
// the next beat can be taken once the sequencer is back in IDLE. A tick that issues
// a move step on a ramp runs a multiply and the shared restoring divider before
// DONE; a full-speed step skips the divider.
// One beat is in work at a time; in_stall stays high until its result sits
// in the output register, and a stalled result blocks only the next result.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, taken when
// no beat is in work. A nonzero write of steps_per_floor recomputes the
// step-in-floor count with the same divider (cfg_ready low until it is done).
// Reset: registers at their defaults, phase homing descent, no result held.
module elevator_stepper_motion_controller #(
	parameter int FLOORS = esmc_pkg::FLOORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [1:0]  floor,
	input  logic        bottom_limit,
	input  logic        driver_fault,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        step_pulse,
	output logic        direction_down,
	output logic [1:0]  floor_now,
	output logic [1:0]  goal_floor,
	output logic        target_valid,
	output logic        heading_up,
	output logic        homing,
	output logic        pos_unknown,
	output logic        moving,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int FW  = $clog2(FLOORS);
	localparam int MTW = FW + 18;
	localparam int CW  = MTW + 2;
	localparam int NW  = esmc_pkg::DIV_NW;
	localparam int DW  = esmc_pkg::DIV_DW;
	localparam logic [FW:0] NONE = (FW+1)'(FLOORS);

	typedef enum logic [2:0] {
		PH_HOME_DOWN,
		PH_HOME_BACK,
		PH_IDLE,
		PH_MOVE,
		PH_DWELL_MID,
		PH_DWELL_END
	} ph_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_DIVGO,
		S_DIV,
		S_DONE,
		S_MODGO,
		S_MOD
	} seq_t;

	seq_t seq_q;

	// configuration
	logic [15:0] min_q, max_q, bper_q;
	logic [17:0] acc_q, dec_q, spf_q;
	logic [23:0] dwell_q;
	logic [7:0]  bsteps_q;

	// item
	esmc_pkg::mode_t mode_q;
	logic [1:0] floor_q;
	logic       lim_q, flt_q;

	// controller state
	ph_t              phase_q;
	logic [FW-1:0]    car_q, tgt_q, dest_q;
	logic             up_q, tv_q, lost_q, dir_q, gd_q, open_q, pulse_q;
	logic [FLOORS-1:0] upr_q, dnr_q;
	logic [MTW-1:0]   si_q, mt_q;
	logic [17:0]      fs_q;
	logic [15:0]      pc_q, hp_q;
	logic [23:0]      dw_q;
	logic [7:0]       bc_q;

	// ramp arithmetic
	logic signed [35:0] prod_q;
	logic               dsel_q;

	// result register
	logic       out_valid_q, step_pulse_q, direction_down_q, target_valid_q;
	logic       heading_up_q, homing_q, pos_unknown_q, moving_q;
	logic [1:0] floor_now_q, goal_floor_q;

	// next-state of one item
	ph_t              n_ph;
	logic [FW-1:0]    n_car, n_tgt, n_dest, bfl, fi, gap;
	logic             n_up, n_tv, n_lost, n_dir, n_gd, n_open, n_pulse;
	logic [FLOORS-1:0] n_upr, n_dnr;
	logic [MTW-1:0]   n_si, n_mt;
	logic [17:0]      n_fs;
	logic [15:0]      n_pc, n_hp;
	logic [23:0]      n_dw;
	logic [7:0]       n_bc;
	logic             need_ramp, do_move, do_idle, do_begin, back, stop, bdown, f_ok;
	logic [FW:0]      sa, sb;
	logic [4:0]       fx, cx;

	// divider hookup
	logic          div_start, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [DW-1:0] div_den, div_rem;

	// ramp helpers
	logic signed [16:0] span;
	logic               in_accel, in_decel;
	logic [17:0]        fac_acc, fac_dec;
	logic signed [35:0] prod_neg;
	logic signed [17:0] sq, pval;

	function automatic logic [FW:0] scan_above(logic [FLOORS-1:0] fl, logic [FW-1:0] car);
		logic [FW:0] r;
		r = NONE;
		for (int i = FLOORS - 1; i >= 0; i--) begin
			if (fl[i] && ((FW+1)'(i) > {1'b0, car})) r = (FW+1)'(i);
		end
		return r;
	endfunction

	function automatic logic [FW:0] scan_below(logic [FLOORS-1:0] fl, logic [FW-1:0] car);
		logic [FW:0] r;
		r = NONE;
		for (int i = 0; i < FLOORS; i++) begin
			if (fl[i] && ((FW+1)'(i) < {1'b0, car})) r = (FW+1)'(i);
		end
		return r;
	endfunction

	assign fx   = 5'(floor_q);
	assign cx   = 5'(car_q);
	assign f_ok = fx < 5'(FLOORS);
	assign fi   = FW'(floor_q);

	always_comb begin
		n_car = car_q;   n_tgt = tgt_q;   n_dest = dest_q;  n_up = up_q;
		n_tv = tv_q;     n_lost = lost_q; n_dir = dir_q;    n_gd = gd_q;
		n_open = open_q; n_upr = upr_q;   n_dnr = dnr_q;    n_ph = phase_q;
		n_si = si_q;     n_mt = mt_q;     n_fs = fs_q;      n_pc = pc_q;
		n_hp = hp_q;     n_dw = dw_q;     n_bc = bc_q;
		n_pulse = 1'b0;  need_ramp = 1'b0; do_move = 1'b0; do_idle = 1'b0;
		do_begin = 1'b0; back = 1'b0;     stop = 1'b0;     bdown = 1'b0;
		bfl = '0;        gap = '0;
		sa = NONE;       sb = NONE;

		case (mode_q)
			esmc_pkg::MODE_BUTTON: begin
				if (f_ok) begin
					if (fx < cx) n_dnr[fi] = 1'b1;
					else n_upr[fi] = 1'b1;
				end
			end
			esmc_pkg::MODE_REQUEST: begin
				if (f_ok && fx != cx) begin
					n_up  = fx > cx;
					n_tgt = fi;
					n_tv  = 1'b1;
					if (n_up) n_upr[fi] = 1'b1;
					else n_dnr[fi] = 1'b1;
				end
			end
			esmc_pkg::MODE_TICK: begin
				case (phase_q) inside
					PH_HOME_DOWN, PH_HOME_BACK: begin
						if (pc_q != 16'd0) begin
							n_pc = pc_q - 16'd1;
						end else begin
							if (phase_q == PH_HOME_DOWN) begin
								if (!lim_q) begin
									n_dir   = 1'b1;
									n_pulse = 1'b1;
									n_si    = MTW'(1);
									n_fs    = (spf_q == 18'd1) ? 18'd0 : 18'd1;
									n_pc    = esmc_pkg::load_period(hp_q);
									if (hp_q > min_q)
										n_hp = (hp_q - min_q >= 16'd2) ? hp_q - 16'd2 : min_q;
								end else begin
									n_car = '0;
									if (si_q == '0) begin
										n_lost = 1'b0;
										n_ph   = PH_IDLE;
									end else begin
										n_ph  = PH_HOME_BACK;
										n_bc  = 8'd0;
										n_dir = 1'b0;
										back  = 1'b1;
									end
								end
							end else begin
								back = 1'b1;
							end
							if (back) begin
								if (n_bc < bsteps_q) begin
									n_dir   = 1'b0;
									n_pulse = 1'b1;
									n_bc    = n_bc + 8'd1;
									n_pc    = esmc_pkg::load_period(bper_q);
								end else begin
									n_car  = '0;
									n_lost = 1'b0;
									n_upr  = '0;
									n_dnr  = '0;
									n_ph   = PH_IDLE;
								end
							end
						end
					end
					PH_MOVE: do_move = 1'b1;
					PH_DWELL_MID, PH_DWELL_END: begin
						if (dw_q != 24'd0) n_dw = dw_q - 24'd1;
						if (n_dw == 24'd0) begin
							if (phase_q == PH_DWELL_MID) begin
								n_ph    = PH_MOVE;
								do_move = 1'b1;
							end else begin
								n_ph    = PH_IDLE;
								do_idle = 1'b1;
							end
						end
					end
					default: do_idle = 1'b1;
				endcase
			end
			default: ;
		endcase

		if (do_idle) begin
			if (lost_q) begin
				n_ph = PH_HOME_DOWN;
				n_si = '0;
				n_fs = 18'd0;
				n_pc = 16'd0;
				n_bc = 8'd0;
				n_hp = max_q;
			end else begin
				if (flt_q) n_lost = 1'b1;
				sa = scan_above(n_upr | n_dnr, n_car);
				sb = scan_below(n_upr | n_dnr, n_car);
				if (n_up) begin
					if (sa != NONE) begin
						do_begin = 1'b1;
						bfl      = sa[FW-1:0];
					end else if (sb != NONE) begin
						n_up = 1'b0;
					end
				end else begin
					if (sb != NONE) begin
						do_begin = 1'b1;
						bfl      = sb[FW-1:0];
					end else if (sa != NONE) begin
						n_up = 1'b1;
					end
				end
			end
		end

		if (do_begin) begin
			n_tgt = bfl;
			n_tv  = 1'b1;
			bdown = !(bfl > n_car);
			gap   = bdown ? n_car - bfl : bfl - n_car;
			if (!n_lost) begin
				if (bdown && lim_q) begin
					n_car      = '0;
					n_upr[bfl] = 1'b0;
					n_dnr[bfl] = 1'b0;
				end else begin
					n_mt    = MTW'(gap) * MTW'(spf_q);
					n_dest  = bfl;
					n_gd    = bdown;
					n_dir   = bdown;
					n_si    = '0;
					n_fs    = 18'd0;
					n_pc    = 16'd0;
					n_open  = 1'b0;
					n_ph    = PH_MOVE;
					do_move = 1'b1;
				end
			end
		end

		if (do_move) begin
			if (n_pc != 16'd0) begin
				n_pc = n_pc - 16'd1;
			end else begin
				if (n_open) begin
					n_open = 1'b0;
					n_si   = n_si + MTW'(1);
					if (spf_q != 18'd0) begin
						// n_fs tracks step_index modulo steps_per_floor
						if ({1'b0, n_fs} + 19'd1 == {1'b0, spf_q}) begin
							n_fs = 18'd0;
							if (n_gd) begin
								if (n_car != '0) n_car = n_car - FW'(1);
							end else if (5'(n_car) + 5'd1 < 5'(FLOORS)) begin
								n_car = n_car + FW'(1);
							end
							if (n_si < n_mt && (n_upr[n_car] || n_dnr[n_car])) begin
								n_upr[n_car] = 1'b0;
								n_dnr[n_car] = 1'b0;
								n_ph = PH_DWELL_MID;
								n_dw = dwell_q;
								stop = 1'b1;
							end
						end else begin
							n_fs = n_fs + 18'd1;
						end
					end
				end
				if (!stop) begin
					if (n_si >= n_mt) begin
						n_car         = n_dest;
						n_upr[n_dest] = 1'b0;
						n_dnr[n_dest] = 1'b0;
						n_ph          = PH_DWELL_END;
						n_dw          = dwell_q;
					end else if (flt_q) begin
						n_lost = 1'b1;
						n_ph   = PH_IDLE;
					end else if (n_gd && lim_q) begin
						n_car         = '0;
						n_upr[n_dest] = 1'b0;
						n_dnr[n_dest] = 1'b0;
						n_ph          = PH_IDLE;
					end else begin
						n_pulse   = 1'b1;
						n_open    = 1'b1;
						need_ramp = 1'b1;
					end
				end
			end
		end
	end

	// trapezoid: select ramp segment from the step count already advanced
	assign span     = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
	assign in_accel = CW'(si_q) < CW'(acc_q);
	assign in_decel = CW'(si_q) + CW'(dec_q) > CW'(mt_q);
	assign fac_acc  = 18'(si_q);
	assign fac_dec  = dec_q - 18'(mt_q - si_q);
	assign prod_neg = -prod_q;

	assign div_start = (seq_q == S_DIVGO) || (seq_q == S_MODGO);
	assign div_num   = (seq_q == S_MODGO) ? NW'(si_q)
	                 : (prod_q[35] ? prod_neg[NW-1:0] : prod_q[NW-1:0]);
	assign div_den   = (seq_q == S_MODGO) ? spf_q : (dsel_q ? dec_q : acc_q);

	assign sq   = prod_q[35] ? -$signed({1'b0, div_quo[16:0]}) : $signed({1'b0, div_quo[16:0]});
	assign pval = dsel_q ? $signed({2'b0, min_q}) + sq : $signed({2'b0, max_q}) - sq;

	esmc_div #(.NW(NW), .DW(DW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= S_IDLE;
			min_q    <= esmc_pkg::MIN_PERIOD_RST;
			max_q    <= esmc_pkg::MAX_PERIOD_RST;
			acc_q    <= esmc_pkg::ACCEL_RST;
			dec_q    <= esmc_pkg::DECEL_RST;
			spf_q    <= esmc_pkg::SPF_RST;
			dwell_q  <= esmc_pkg::DWELL_RST;
			bsteps_q <= esmc_pkg::BACKOFF_RST;
			bper_q   <= esmc_pkg::BACKOFF_PER_RST;
			phase_q  <= PH_HOME_DOWN;
			car_q    <= '0;
			tgt_q    <= '0;
			dest_q   <= '0;
			up_q     <= 1'b1;
			tv_q     <= 1'b0;
			lost_q   <= 1'b0;
			dir_q    <= 1'b0;
			gd_q     <= 1'b0;
			open_q   <= 1'b0;
			pulse_q  <= 1'b0;
			upr_q    <= '0;
			dnr_q    <= '0;
			si_q     <= '0;
			mt_q     <= '0;
			fs_q     <= 18'd0;
			pc_q     <= 16'd0;
			hp_q     <= esmc_pkg::HOMING_PER_RST;
			dw_q     <= 24'd0;
			bc_q     <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			// S_DONE reloads the result register itself
			if (out_valid_q && !out_stall && seq_q != S_DONE) out_valid_q <= 1'b0;

			unique case (seq_q)
				S_IDLE: begin
					if (cfg_valid) begin
						unique case (cfg_index)
							esmc_pkg::REG_MIN_PERIOD:  min_q    <= cfg_data[15:0];
							esmc_pkg::REG_MAX_PERIOD:  max_q    <= cfg_data[15:0];
							esmc_pkg::REG_ACCEL:       acc_q    <= cfg_data[17:0];
							esmc_pkg::REG_DECEL:       dec_q    <= cfg_data[17:0];
							esmc_pkg::REG_SPF: begin
								spf_q <= cfg_data[17:0];
								if (cfg_data[17:0] != 18'd0) seq_q <= S_MODGO;
							end
							esmc_pkg::REG_DWELL:       dwell_q  <= cfg_data;
							esmc_pkg::REG_BACKOFF:     bsteps_q <= cfg_data[7:0];
							esmc_pkg::REG_BACKOFF_PER: bper_q   <= cfg_data[15:0];
						endcase
					end else if (in_valid) begin
						mode_q  <= esmc_pkg::mode_t'(mode);
						floor_q <= floor;
						lim_q   <= bottom_limit;
						flt_q   <= driver_fault;
						seq_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					phase_q <= n_ph;   car_q <= n_car;   tgt_q <= n_tgt;  dest_q <= n_dest;
					up_q <= n_up;      tv_q <= n_tv;     lost_q <= n_lost; dir_q <= n_dir;
					gd_q <= n_gd;      open_q <= n_open; pulse_q <= n_pulse;
					upr_q <= n_upr;    dnr_q <= n_dnr;   si_q <= n_si;    mt_q <= n_mt;
					fs_q <= n_fs;      pc_q <= n_pc;     hp_q <= n_hp;    dw_q <= n_dw;
					bc_q <= n_bc;
					seq_q <= need_ramp ? S_MUL : S_DONE;
				end
				S_MUL: begin
					if (in_accel) begin
						prod_q <= span * $signed({1'b0, fac_acc});
						dsel_q <= 1'b0;
						seq_q  <= S_DIVGO;
					end else if (in_decel) begin
						prod_q <= span * $signed({1'b0, fac_dec});
						dsel_q <= 1'b1;
						seq_q  <= S_DIVGO;
					end else begin
						pc_q  <= esmc_pkg::load_period(min_q);
						seq_q <= S_DONE;
					end
				end
				S_DIVGO: seq_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						pc_q  <= esmc_pkg::load_period(pval[15:0]);
						seq_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q      <= 1'b1;
						step_pulse_q     <= pulse_q;
						direction_down_q <= dir_q;
						floor_now_q      <= 2'(car_q);
						goal_floor_q     <= 2'(tgt_q);
						target_valid_q   <= tv_q;
						heading_up_q     <= up_q;
						homing_q         <= (phase_q == PH_HOME_DOWN) || (phase_q == PH_HOME_BACK);
						pos_unknown_q    <= lost_q;
						moving_q         <= (phase_q == PH_MOVE) || (phase_q == PH_DWELL_MID)
						                    || (phase_q == PH_DWELL_END);
						seq_q            <= S_IDLE;
					end
				end
				S_MODGO: seq_q <= S_MOD;
				S_MOD: begin
					if (div_done) begin
						fs_q  <= div_rem;
						seq_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign in_stall       = (seq_q != S_IDLE) || cfg_valid;
	assign cfg_ready      = seq_q == S_IDLE;
	assign out_valid      = out_valid_q;
	assign step_pulse     = step_pulse_q;
	assign direction_down = direction_down_q;
	assign floor_now      = floor_now_q;
	assign goal_floor     = goal_floor_q;
	assign target_valid   = target_valid_q;
	assign heading_up     = heading_up_q;
	assign homing         = homing_q;
	assign pos_unknown    = pos_unknown_q;
	assign moving         = moving_q;

`ifndef NO_ASSERTIONS
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (seq_q == S_DIV || seq_q == S_MOD))
		else $error("divider finished with no consumer");

	a_floor_count: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == S_IDLE && spf_q != 18'd0) |-> fs_q < spf_q)
		else $error("step-in-floor count out of range");

	a_pulse_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == S_DONE && pulse_q) |-> mode_q == esmc_pkg::MODE_TICK)
		else $error("step pulse on a non-tick beat");

	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(homing_q && moving_q))
		else $error("homing and moving both reported");

	a_ramp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == S_EXEC && need_ramp) |=> (phase_q == PH_MOVE && open_q))
		else $error("ramped step without an open move step");
`endif

endmodule

[src/esmc_div.sv]
`timescale 1ns / 1ps

module esmc_div #(
	parameter int NW = esmc_pkg::DIV_NW,
	parameter int DW = esmc_pkg::DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic          fits;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= num;
				rem_q  <= '0;
				den_q  <= den;
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// one restoring step per cycle
				rem_q <= fits ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
				quo_q <= {quo_q[NW-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule
